[rtl/dual_reload_timer_irq_macros.svh]
// Assertion macros shared by the timer block.
`ifndef DUAL_RELOAD_TIMER_IRQ_MACROS_SVH
`define DUAL_RELOAD_TIMER_IRQ_MACROS_SVH

// The consequent must hold in the same cycle as the trigger.
`define DRT_ASSERT_NOW(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define DRT_ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

[rtl/drt_pkg.sv]
package drt_pkg;

   typedef enum logic [1:0] {
      KIND_ADDR = 2'd0,
      KIND_DATA = 2'd1,
      KIND_READ = 2'd2,
      KIND_TICK = 2'd3
   } drt_kind_type;

   localparam logic [7:0] ADDR_LOAD_A_HIGH = 8'h10;
   localparam logic [7:0] ADDR_LOAD_A_LOW  = 8'h11;
   localparam logic [7:0] ADDR_LOAD_B      = 8'h12;
   localparam logic [7:0] ADDR_CONTROL     = 8'h14;

   localparam int STATUS_BUSY_BIT = 7;

   localparam int PRESCALE_A_DEFAULT = 64;
   localparam int B_RATIO_DEFAULT    = 16;
   localparam int BUSY_TICKS_DEFAULT = 64;

   // Command from the bus decoder to the timer unit.
   typedef struct packed {
      logic       tick;
      logic       ctrl_wr;
      logic [7:0] ctrl;
   } drt_cmd_type;

   // Flag and interrupt state as it stands after the current beat.
   typedef struct packed {
      logic [1:0] flags;
      logic       irq;
   } drt_timer_status_type;

endpackage

[rtl/drt_timers.sv]
module drt_timers #(
   parameter int PRESCALE_A = drt_pkg::PRESCALE_A_DEFAULT,
   parameter int B_RATIO    = drt_pkg::B_RATIO_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  drt_pkg::drt_cmd_type           cmd,
   input  logic [9:0]                     load_a,
   input  logic [7:0]                     load_b,
   output drt_pkg::drt_timer_status_type  status_next
);
   import drt_pkg::*;

   localparam int PS_W = (PRESCALE_A > 1) ? $clog2(PRESCALE_A) : 1;
   localparam int BS_W = (B_RATIO > 1) ? $clog2(B_RATIO) : 1;

   logic [1:0]      run_ff, run_in;
   logic [1:0]      enable_ff, enable_in;
   logic [1:0]      flag_ff, flag_in;
   logic [9:0]      count_a_ff, count_a_in;
   logic [7:0]      count_b_ff, count_b_in;
   logic [PS_W-1:0] prescale_ff, prescale_in;
   logic [BS_W-1:0] bsub_ff, bsub_in;
   logic [PS_W:0]   prescale_sum;
   logic [BS_W:0]   bsub_sum;

   assign prescale_sum = {1'b0, prescale_ff} + {{PS_W{1'b0}}, 1'b1};
   assign bsub_sum     = {1'b0, bsub_ff} + {{BS_W{1'b0}}, 1'b1};

   always_comb begin
      run_in      = run_ff;
      enable_in   = enable_ff;
      flag_in     = flag_ff;
      count_a_in  = count_a_ff;
      count_b_in  = count_b_ff;
      prescale_in = prescale_ff;
      bsub_in     = bsub_ff;
      if (cmd.ctrl_wr) begin
         // On a control write, only a stopped-to-running edge reloads a counter.
         if (cmd.ctrl[0] && !run_ff[0]) begin
            count_a_in = load_a;
         end
         if (cmd.ctrl[1] && !run_ff[1]) begin
            count_b_in = load_b;
         end
         run_in    = cmd.ctrl[1:0];
         enable_in = cmd.ctrl[3:2];
         flag_in   = flag_ff & ~cmd.ctrl[5:4];
      end
      if (cmd.tick) begin
         if (prescale_sum == (PS_W+1)'(PRESCALE_A)) begin
            prescale_in = '0;
            if (run_ff[0]) begin
               if (count_a_ff == 10'h3FF) begin
                  count_a_in = load_a;
                  flag_in[0] = 1'b1;
               end else begin
                  count_a_in = count_a_ff + 10'd1;
               end
            end
            if (bsub_sum == (BS_W+1)'(B_RATIO)) begin
               bsub_in = '0;
               if (run_ff[1]) begin
                  if (count_b_ff == 8'hFF) begin
                     count_b_in = load_b;
                     flag_in[1] = 1'b1;
                  end else begin
                     count_b_in = count_b_ff + 8'd1;
                  end
               end
            end else begin
               bsub_in = bsub_sum[BS_W-1:0];
            end
         end else begin
            prescale_in = prescale_sum[PS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= '0;
         enable_ff   <= '0;
         flag_ff     <= '0;
         count_a_ff  <= '0;
         count_b_ff  <= '0;
         prescale_ff <= '0;
         bsub_ff     <= '0;
      end else begin
         run_ff      <= run_in;
         enable_ff   <= enable_in;
         flag_ff     <= flag_in;
         count_a_ff  <= count_a_in;
         count_b_ff  <= count_b_in;
         prescale_ff <= prescale_in;
         bsub_ff     <= bsub_in;
      end
   end

   assign status_next.flags = flag_in;
   assign status_next.irq   = |(flag_in & enable_in);

endmodule

[rtl/dual_reload_timer_irq.sv]
// Timer, status and interrupt section of an FM sound chip.
// Request channel (req_*): each beat carries a kind and a bus byte. Kinds are
// an address write, a data write, a status read and one input clock tick.
// Data writes to the latched address load timer A (high byte, low two bits),
// load timer B, or write the control register (run, interrupt enable and
// write-one-to-clear flag bits); every data write restarts the busy countdown.
// Response channel (rsp_*): exactly one beat per request beat, in order. It
// carries the status byte (flags and busy on reads, zero otherwise) and the
// interrupt level as it stands after the request took effect.
// Each response is registered, shown in the cycle after its request is taken;
// one request per cycle while rsp_ready is high. The whole update is a single
// combinational pass between the request handshake and the response register.
// The response register is the only buffer: while rsp_ready is low and a
// response is held, req_ready drops, and it rises in the same cycle that the
// held response is taken. Reset (synchronous) stops both timers, clears the
// flags, enables, loads, prescaler and busy countdown, and empties the
// response register.
module dual_reload_timer_irq #(
   parameter int PRESCALE_A = drt_pkg::PRESCALE_A_DEFAULT,
   parameter int B_RATIO    = drt_pkg::B_RATIO_DEFAULT,
   parameter int BUSY_TICKS = drt_pkg::BUSY_TICKS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_bus_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_status_byte,
   output logic       rsp_irq_level
);
   import drt_pkg::*;

   localparam int BUSY_W = (BUSY_TICKS > 0) ? $clog2(BUSY_TICKS + 1) : 1;

   logic [7:0]        address_ff, address_in;
   logic [7:0]        load_a_high_ff, load_a_high_in;
   logic [1:0]        load_a_low_ff, load_a_low_in;
   logic [7:0]        load_b_ff, load_b_in;
   logic [BUSY_W-1:0] busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        status_ff, status_in;
   logic              irq_ff, irq_in;
   logic              accept;
   drt_cmd_type          cmd;
   drt_timer_status_type tstat;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      address_in     = address_ff;
      load_a_high_in = load_a_high_ff;
      load_a_low_in  = load_a_low_ff;
      load_b_in      = load_b_ff;
      busy_in        = busy_ff;
      cmd.tick       = 1'b0;
      cmd.ctrl_wr    = 1'b0;
      cmd.ctrl       = req_bus_value;
      if (accept) begin
         unique case (drt_kind_type'(req_kind))
            KIND_ADDR: begin
               address_in = req_bus_value;
            end
            KIND_DATA: begin
               busy_in = BUSY_W'(BUSY_TICKS);
               unique case (address_ff)
                  ADDR_LOAD_A_HIGH: load_a_high_in = req_bus_value;
                  ADDR_LOAD_A_LOW:  load_a_low_in  = req_bus_value[1:0];
                  ADDR_LOAD_B:      load_b_in      = req_bus_value;
                  ADDR_CONTROL:     cmd.ctrl_wr    = 1'b1;
                  default: ;
               endcase
            end
            KIND_READ: ;
            KIND_TICK: begin
               cmd.tick = 1'b1;
               if (busy_ff != '0) begin
                  busy_in = busy_ff - BUSY_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // A read changes no state, so the flags seen here are the stored ones.
   always_comb begin
      status_in = '0;
      if (accept && (drt_kind_type'(req_kind) == KIND_READ)) begin
         status_in[1:0]             = tstat.flags;
         status_in[STATUS_BUSY_BIT] = (busy_ff != '0);
      end
   end

   drt_timers #(
      .PRESCALE_A(PRESCALE_A),
      .B_RATIO   (B_RATIO)
   ) u_timers (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .load_a     ({load_a_high_ff, load_a_low_ff}),
      .load_b     (load_b_ff),
      .status_next(tstat)
   );

   assign irq_in       = tstat.irq;
   assign rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff     <= '0;
         load_a_high_ff <= '0;
         load_a_low_ff  <= '0;
         load_b_ff      <= '0;
         busy_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         address_ff     <= address_in;
         load_a_high_ff <= load_a_high_in;
         load_a_low_ff  <= load_a_low_in;
         load_b_ff      <= load_b_in;
         busy_ff        <= busy_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Response payload loads only with a new beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         irq_ff    <= irq_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status_byte = status_ff;
   assign rsp_irq_level   = irq_ff;

`include "dual_reload_timer_irq_macros.svh"

   `DRT_ASSERT_NEXT(a_rsp_follows_req, accept, rsp_valid_ff, "accepted beat lost its response")
   `DRT_ASSERT_NEXT(a_status_only_on_read, accept && (req_kind != KIND_READ),
      status_ff == 8'h00, "status byte nonzero on a non-read beat")
   `DRT_ASSERT_NEXT(a_busy_restart, accept && (req_kind == KIND_DATA),
      busy_ff == BUSY_W'(BUSY_TICKS), "data write did not restart busy countdown")
   `DRT_ASSERT_NOW(a_status_reserved_zero, rsp_valid_ff, status_ff[6:2] == 5'd0,
      "reserved status bits set")

endmodule
